// ----- rtl/tspc_pkg.sv -----
// Package for the transport stream header parser with per-PID packet counter.
// Holds stream constants, header field layout and default widths.
// No dependencies.
package tspc_pkg;

  // Stream constants
  localparam logic [7:0] SYNC_VALUE      = 8'h47;
  localparam int         LEN_BITS        = 10;
  localparam logic [LEN_BITS-1:0] DEFAULT_LENGTH = LEN_BITS'(188);
  localparam logic [LEN_BITS-1:0] MIN_LENGTH     = LEN_BITS'(4);
  localparam int         HDR_BITS        = 24;

  // PID table geometry
  localparam int         PID_BITS        = 13;
  localparam int         PID_ENTRIES     = 1 << PID_BITS;

  // Default widths of the saturating counters
  localparam int         DEF_COUNT_BITS  = 32;
  localparam int         DEF_OFFSET_BITS = 48;

  // Header byte 1 and byte 3 field masks
  localparam logic [7:0] ERR_MASK        = 8'h80;
  localparam logic [7:0] PID_HI_MASK     = 8'h1f;
  localparam logic [7:0] SCR_MASK        = 8'hc0;
  localparam logic [7:0] ADAPT_MASK      = 8'h30;
  localparam logic [7:0] CC_MASK         = 8'h0f;

endpackage

// ----- rtl/ts_header_parser_pid_counter_core.sv -----
// Top level of the transport stream header parser with per-PID packet counter.
// Depends on tspc_pkg for constants and default widths.
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+----------------
//  in      | in_data_byte                            | input     | in_valid/ready
//  out     | out_packet_offset .. out_pid_packets    | output    | out_valid/ready
//  cfg     | cfg_wdata (packet length)               | input     | cfg_we only
//
// Throughput is one byte beat per cycle while in_ready is high. The last
// byte beat of a packet goes via the holding stage and one read of the PID
// count memory to the output register and out_valid. Cfg writes are taken
// throughout. After reset in_ready is low while the count memory is cleared
// one entry per cycle. A finished packet waits in the one-entry holding stage,
// then the output register; in_ready also drops while both are full and stalled.
module ts_header_parser_pid_counter_core #(
  parameter int COUNT_BITS  = tspc_pkg::DEF_COUNT_BITS,
  parameter int OFFSET_BITS = tspc_pkg::DEF_OFFSET_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [tspc_pkg::LEN_BITS-1:0]     cfg_wdata,
  // byte input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  // packet result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [OFFSET_BITS-1:0]            out_packet_offset,
  output logic                              out_error_indicator,
  output logic                              out_unit_start,
  output logic                              out_priority_bit,
  output logic [tspc_pkg::PID_BITS-1:0]     out_packet_pid,
  output logic [1:0]                        out_scrambling,
  output logic [1:0]                        out_adaptation,
  output logic [3:0]                        out_continuity,
  output logic [COUNT_BITS-1:0]             out_pid_packets
);
  import tspc_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

  // Parser state
  logic [LEN_BITS-1:0]    len_r;
  logic [LEN_BITS-1:0]    bytes_left_r, bytes_left_nxt;
  logic [HDR_BITS-1:0]    header_r, header_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] sync_pos_r, sync_pos_nxt;

  // Holding stage between byte accept and count update
  logic                   hold_vld_r, hold_vld_nxt;
  logic [OFFSET_BITS-1:0] hold_offset_r;
  logic [HDR_BITS-1:0]    hold_header_r;

  // Output register
  logic                   out_vld_r, out_vld_nxt;
  logic [OFFSET_BITS-1:0] out_offset_r;
  logic [HDR_BITS-1:0]    out_header_r;
  logic [COUNT_BITS-1:0]  out_count_r;

  // Clearing pass
  logic                   clr_busy_r;
  logic [PID_BITS-1:0]    clr_idx_r;

  // Count memory and its read bypass
  logic [COUNT_BITS-1:0]  cnt_mem [PID_ENTRIES];
  logic [COUNT_BITS-1:0]  mem_q_r;
  logic                   byp_r;
  logic [COUNT_BITS-1:0]  byp_data_r;
  logic                   rd_en;
  logic [PID_BITS-1:0]    rd_addr;
  logic                   wr_en;
  logic [PID_BITS-1:0]    wr_addr;
  logic [COUNT_BITS-1:0]  wr_data;
  logic [COUNT_BITS-1:0]  cnt_cur;
  logic [COUNT_BITS-1:0]  cnt_inc;

  logic                   in_acc;
  logic                   hold_move;
  logic                   pkt_done;
  logic [LEN_BITS-1:0]    len_eff;
  logic [LEN_BITS-1:0]    pkt_idx;

  // Handshake
  assign hold_move = !out_vld_r || out_ready;
  assign in_ready  = !clr_busy_r && (!hold_vld_r || hold_move);
  assign in_acc    = in_valid && in_ready;

  // Byte parser: sync hunt, header capture, packet countdown
  always_comb begin
    len_eff        = (len_r < MIN_LENGTH) ? MIN_LENGTH : len_r;
    pkt_idx        = len_eff - bytes_left_r;
    bytes_left_nxt = bytes_left_r;
    header_nxt     = header_r;
    sync_pos_nxt   = sync_pos_r;
    pos_nxt        = pos_r;
    pkt_done       = 1'b0;
    if (in_acc) begin
      if (pos_r != OFFSET_MAX) begin
        pos_nxt = pos_r + OFFSET_BITS'(1);
      end
      if (bytes_left_r == '0) begin
        if (in_data_byte == SYNC_VALUE) begin
          sync_pos_nxt   = pos_r;
          header_nxt     = '0;
          bytes_left_nxt = len_eff - LEN_BITS'(1);
        end
      end else begin
        if (bytes_left_r <= len_eff) begin
          unique case (pkt_idx)
            LEN_BITS'(1): header_nxt[23:16] = in_data_byte;
            LEN_BITS'(2): header_nxt[15:8]  = in_data_byte;
            LEN_BITS'(3): header_nxt[7:0]   = in_data_byte;
            default:      header_nxt        = header_r;
          endcase
        end
        bytes_left_nxt = bytes_left_r - LEN_BITS'(1);
        pkt_done       = (bytes_left_nxt == '0);
      end
    end
  end

  // Holding stage and output register valid flags
  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (pkt_done) begin
      hold_vld_nxt = 1'b1;
    end else if (hold_move) begin
      hold_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (hold_vld_r && hold_move) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Count memory ports: read at packet end, write on result hand-off
  always_comb begin
    rd_en   = pkt_done;
    rd_addr = {header_nxt[20:16], header_nxt[15:8]};
    cnt_cur = byp_r ? byp_data_r : mem_q_r;
    cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = '0;
    end else begin
      wr_en   = hold_vld_r && hold_move;
      wr_addr = {hold_header_r[20:16], hold_header_r[15:8]};
      wr_data = cnt_inc;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= DEFAULT_LENGTH;
      bytes_left_r <= '0;
      header_r     <= '0;
      pos_r        <= '0;
      sync_pos_r   <= '0;
      hold_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
      clr_busy_r   <= 1'b1;
      clr_idx_r    <= '0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      bytes_left_r <= bytes_left_nxt;
      header_r     <= header_nxt;
      pos_r        <= pos_nxt;
      sync_pos_r   <= sync_pos_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      // advance the clearing pass, stop after the last entry
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + PID_BITS'(1);
        if (clr_idx_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // Payload registers: capture at packet end, hand off to output
  always_ff @(posedge clk) begin
    if (pkt_done) begin
      hold_offset_r <= sync_pos_nxt;
      hold_header_r <= header_nxt;
    end
    if (hold_vld_r && hold_move) begin
      out_offset_r <= hold_offset_r;
      out_header_r <= hold_header_r;
      out_count_r  <= cnt_inc;
    end
  end

  // Count memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
  end

  // Count memory read port; forward a same-cycle write to the same PID
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r    <= cnt_mem[rd_addr];
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  // Decode header fields
  assign out_valid           = out_vld_r;
  assign out_packet_offset   = out_offset_r;
  assign out_error_indicator = |(out_header_r[23:16] & ERR_MASK);
  assign out_unit_start      = out_header_r[22];
  assign out_priority_bit    = out_header_r[21];
  assign out_packet_pid      = {out_header_r[20:16] & PID_HI_MASK[4:0], out_header_r[15:8]};
  assign out_scrambling      = out_header_r[7:6] & SCR_MASK[7:6];
  assign out_adaptation      = out_header_r[5:4] & ADAPT_MASK[5:4];
  assign out_continuity      = out_header_r[3:0] & CC_MASK[3:0];
  assign out_pid_packets     = out_count_r;

endmodule
